// File: rtl/core/caeu_pkg.sv
`timescale 1ns / 1ps

package caeu_pkg;

    localparam int CmdWidth  = 5;
    localparam int ByteWidth = 8;
    localparam int InWidth   = 16;
    localparam int OutWidth  = 16;

    typedef enum logic [CmdWidth-1:0] {
        CMD_ORA = 5'd0,
        CMD_AND = 5'd1,
        CMD_EOR = 5'd2,
        CMD_ADC = 5'd3,
        CMD_SBC = 5'd4,
        CMD_CMP = 5'd5,
        CMD_CPX = 5'd6,
        CMD_CPY = 5'd7,
        CMD_BIT = 5'd8,
        CMD_LDA = 5'd9,
        CMD_LDX = 5'd10,
        CMD_LDY = 5'd11,
        CMD_STA = 5'd12,
        CMD_STX = 5'd13,
        CMD_STY = 5'd14,
        CMD_ASL = 5'd15,
        CMD_LSR = 5'd16,
        CMD_ROL = 5'd17,
        CMD_ROR = 5'd18,
        CMD_INC = 5'd19,
        CMD_DEC = 5'd20
    } cmd_t;

    typedef struct packed {
        logic n;
        logic v;
        logic z;
        logic c;
    } flags_t;

    localparam logic [ByteWidth-1:0] ByteZero = 8'h00;
    localparam logic [ByteWidth-1:0] ByteOne  = 8'h01;

endpackage

// File: rtl/core/cpu_alu_execute_unit.sv
`timescale 1ns / 1ps

// throughput: one request per cycle, sustained as long as m_tready stays high
// stage 1 registers the request, stage 2 runs the alu against a, x, y and flags
// and loads the result register; registers and flags update as stage 2 fires
// reset (rst_n low, asynchronous): pipeline empty, a, x, y and all flags zero
module cpu_alu_execute_unit
    import caeu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InWidth-1:0]  s_tdata,   // [4:0] cmd, [12:5] operand, [15:13] zero
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutWidth-1:0] m_tdata    // [7:0] result, [8] write_back, [9] flag_n,
                                           // [10] flag_v, [11] flag_z, [12] flag_c,
                                           // [15:13] zero
);

    // stage 1: registered request
    logic                 in_valid_reg;
    logic [CmdWidth-1:0]  in_cmd_reg;
    logic [ByteWidth-1:0] in_operand_reg;

    // stage 2: result register
    logic                 out_valid_reg;
    logic [OutWidth-1:0]  out_data_reg;
    logic [OutWidth-1:0]  out_data_next;

    // architectural state
    logic [ByteWidth-1:0] acc_reg, acc_next;
    logic [ByteWidth-1:0] x_reg, x_next;
    logic [ByteWidth-1:0] y_reg, y_next;
    flags_t               flags_reg, flags_next;

    logic                 s_fire;
    logic                 exec_fire;

    // alu datapath
    logic [ByteWidth-1:0] alu_res;
    logic                 alu_wb;
    logic [ByteWidth-1:0] add_m;
    logic [ByteWidth:0]   add_sum;
    logic [ByteWidth-1:0] cmp_reg;
    logic [ByteWidth:0]   cmp_diff;
    logic [ByteWidth-1:0] m;

    // stage 2 moves when the result register is free or being drained
    assign exec_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || exec_fire;
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign m = in_operand_reg;

    // shared adder: sbc adds the inverted operand
    always_comb
    begin
        add_m   = (cmd_t'(in_cmd_reg) == CMD_SBC) ? ~m : m;
        add_sum = {1'b0, acc_reg} + {1'b0, add_m} + {{ByteWidth{1'b0}}, flags_reg.c};
    end

    // shared compare subtractor, borrow out in the top bit
    always_comb
    begin
        case (cmd_t'(in_cmd_reg))
            CMD_CPX: cmp_reg = x_reg;
            CMD_CPY: cmp_reg = y_reg;
            default: cmp_reg = acc_reg;
        endcase
        cmp_diff = {1'b0, cmp_reg} - {1'b0, m};
    end

    always_comb
    begin
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        flags_next = flags_reg;
        alu_res    = ByteZero;
        alu_wb     = 1'b0;

        case (cmd_t'(in_cmd_reg))
            CMD_ORA:
            begin
                alu_res  = acc_reg | m;
                acc_next = alu_res;
            end
            CMD_AND:
            begin
                alu_res  = acc_reg & m;
                acc_next = alu_res;
            end
            CMD_EOR:
            begin
                alu_res  = acc_reg ^ m;
                acc_next = alu_res;
            end
            CMD_ADC, CMD_SBC:
            begin
                alu_res      = add_sum[ByteWidth-1:0];
                acc_next     = alu_res;
                flags_next.c = add_sum[ByteWidth];
                flags_next.v = ~(acc_reg[ByteWidth-1] ^ add_m[ByteWidth-1])
                             & (acc_reg[ByteWidth-1] ^ alu_res[ByteWidth-1]);
            end
            CMD_CMP, CMD_CPX, CMD_CPY:
            begin
                alu_res      = cmp_diff[ByteWidth-1:0];
                flags_next.c = ~cmp_diff[ByteWidth];
            end
            CMD_BIT:
            begin
                alu_res = acc_reg & m;
            end
            CMD_LDA:
            begin
                alu_res  = m;
                acc_next = m;
            end
            CMD_LDX:
            begin
                alu_res = m;
                x_next  = m;
            end
            CMD_LDY:
            begin
                alu_res = m;
                y_next  = m;
            end
            CMD_STA:
            begin
                alu_res = acc_reg;
                alu_wb  = 1'b1;
            end
            CMD_STX:
            begin
                alu_res = x_reg;
                alu_wb  = 1'b1;
            end
            CMD_STY:
            begin
                alu_res = y_reg;
                alu_wb  = 1'b1;
            end
            CMD_ASL:
            begin
                alu_res      = {m[ByteWidth-2:0], 1'b0};
                flags_next.c = m[ByteWidth-1];
                alu_wb       = 1'b1;
            end
            CMD_LSR:
            begin
                alu_res      = {1'b0, m[ByteWidth-1:1]};
                flags_next.c = m[0];
                alu_wb       = 1'b1;
            end
            CMD_ROL:
            begin
                // incoming bit is the carry held before this op
                alu_res      = {m[ByteWidth-2:0], flags_reg.c};
                flags_next.c = m[ByteWidth-1];
                alu_wb       = 1'b1;
            end
            CMD_ROR:
            begin
                alu_res      = {flags_reg.c, m[ByteWidth-1:1]};
                flags_next.c = m[0];
                alu_wb       = 1'b1;
            end
            CMD_INC:
            begin
                alu_res = m + ByteOne;
                alu_wb  = 1'b1;
            end
            CMD_DEC:
            begin
                alu_res = m - ByteOne;
                alu_wb  = 1'b1;
            end
            default:
            begin
                // unused codes: nothing changes, result reads zero
                alu_res = ByteZero;
            end
        endcase

        // n and z follow the result except for stores and unused codes; bit test takes n from the operand
        case (cmd_t'(in_cmd_reg))
            CMD_ORA, CMD_AND, CMD_EOR, CMD_ADC, CMD_SBC, CMD_CMP, CMD_CPX, CMD_CPY,
            CMD_LDA, CMD_LDX, CMD_LDY, CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR,
            CMD_INC, CMD_DEC:
            begin
                flags_next.n = alu_res[ByteWidth-1];
                flags_next.z = (alu_res == ByteZero);
            end
            CMD_BIT:
            begin
                // bit test: n and v come straight from the operand
                flags_next.n = m[ByteWidth-1];
                flags_next.v = m[ByteWidth-2];
                flags_next.z = (alu_res == ByteZero);
            end
            default:
            begin
                flags_next = flags_next;
            end
        endcase

        out_data_next = {3'b000, flags_next.c, flags_next.z, flags_next.v, flags_next.n,
                         alu_wb, alu_res};
    end

    // stage 1: request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_cmd_reg     <= s_tdata[CmdWidth-1:0];
            in_operand_reg <= s_tdata[CmdWidth +: ByteWidth];
        end
    end

    // stage 2: result register and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_reg       <= ByteZero;
            x_reg         <= ByteZero;
            y_reg         <= ByteZero;
            flags_reg     <= '0;
        end
        else
        begin
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                x_reg         <= x_next;
                y_reg         <= y_next;
                flags_reg     <= flags_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
